/* src/qsr_pkg.sv */
// Package for the quadratic root solver: payload types, status codes, widths.
package qsr_pkg;

  // Input word: signed Q16.16 coefficients.
  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
  } qsr_in_t;

  // Result word: unsigned Q16.16 root and status.
  typedef struct packed {
    logic [31:0] root;
    logic [1:0]  status;
  } qsr_out_t;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_COMPLEX = 2'd1,
    ST_NONEG   = 2'd2,
    ST_AZERO   = 2'd3
  } qsr_status_t;

  localparam int unsigned RadW  = 98;  // scaled discriminant width
  localparam int unsigned SqrtW = 49;  // root bits
  localparam int unsigned NumW  = 50;  // candidate magnitude width
  localparam int unsigned DenW  = 33;  // |2a| width
  localparam int unsigned QW    = NumW; // quotient width

  // Data carried alongside the datapath through every cell.
  typedef struct packed {
    logic              valid;
    logic              done;     // result already decided
    logic [1:0]        status;
    logic signed [33:0] nb_hi;   // -b; the candidate stage scales it by 2^16
    logic              den_neg;
    logic [DenW-1:0]   den_mag;
  } qsr_side_t;

endpackage

/* src/qsr_sqrt_cell.sv */
// One restoring square-root cell: settles one result bit per stage.
module qsr_sqrt_cell import qsr_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qsr_side_t           side_i,
  input  logic [SqrtW-1:0]    q_i,
  input  logic [RadW-1:0]     rem_i,
  output qsr_side_t           side_o,
  output logic [SqrtW-1:0]    q_o,
  output logic [RadW-1:0]     rem_o
);

  // rem = rad - q^2; trial with bit set costs (2q + 2^Bit) * 2^Bit
  logic [RadW:0]    trial;
  logic             take;
  logic [SqrtW-1:0] q_nxt;
  logic [RadW-1:0]  rem_nxt;

  always_comb begin
    trial   = (({{(RadW+1-SqrtW){1'b0}}, q_i} << 1) +
               ({{RadW{1'b0}}, 1'b1} << Bit)) << Bit;
    take    = trial <= {1'b0, rem_i};
    q_nxt   = take ? (q_i | (SqrtW'(1) << Bit)) : q_i;
    rem_nxt = take ? RadW'({1'b0, rem_i} - trial) : rem_i;
  end

  qsr_side_t        side_r;
  logic [SqrtW-1:0] q_r;
  logic [RadW-1:0]  rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r.valid <= side_i.valid;
    end
    side_r.done    <= side_i.done;
    side_r.status  <= side_i.status;
    side_r.nb_hi   <= side_i.nb_hi;
    side_r.den_neg <= side_i.den_neg;
    side_r.den_mag <= side_i.den_mag;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign side_o = side_r;
  assign q_o    = q_r;
  assign rem_o  = rem_r;

endmodule

/* src/qsr_div_cell.sv */
// One restoring divider cell: two quotients, one bit each per stage.
module qsr_div_cell import qsr_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  qsr_side_t       side_i,
  input  logic [1:0]      ok_i,
  input  logic [NumW-1:0] rem0_i,
  input  logic [NumW-1:0] rem1_i,
  input  logic [QW-1:0]   q0_i,
  input  logic [QW-1:0]   q1_i,
  output qsr_side_t       side_o,
  output logic [1:0]      ok_o,
  output logic [NumW-1:0] rem0_o,
  output logic [NumW-1:0] rem1_o,
  output logic [QW-1:0]   q0_o,
  output logic [QW-1:0]   q1_o
);

  // shifted divisor compared against the partial remainder
  logic [NumW+DenW-1:0] dsh;
  logic                 t0, t1;

  always_comb begin
    dsh = {{NumW{1'b0}}, side_i.den_mag} << Bit;
    t0  = dsh <= {{DenW{1'b0}}, rem0_i};
    t1  = dsh <= {{DenW{1'b0}}, rem1_i};
  end

  qsr_side_t       side_r;
  logic [1:0]      ok_r;
  logic [NumW-1:0] rem0_r, rem1_r;
  logic [QW-1:0]   q0_r, q1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r.valid <= side_i.valid;
    end
    side_r.done    <= side_i.done;
    side_r.status  <= side_i.status;
    side_r.nb_hi   <= side_i.nb_hi;
    side_r.den_neg <= side_i.den_neg;
    side_r.den_mag <= side_i.den_mag;
    ok_r   <= ok_i;
    rem0_r <= t0 ? NumW'({{DenW{1'b0}}, rem0_i} - dsh) : rem0_i;
    rem1_r <= t1 ? NumW'({{DenW{1'b0}}, rem1_i} - dsh) : rem1_i;
    q0_r   <= t0 ? (q0_i | (QW'(1) << Bit)) : q0_i;
    q1_r   <= t1 ? (q1_i | (QW'(1) << Bit)) : q1_i;
  end

  assign side_o = side_r;
  assign ok_o   = ok_r;
  assign rem0_o = rem0_r;
  assign rem1_o = rem1_r;
  assign q0_o   = q0_r;
  assign q1_o   = q1_r;

endmodule

/* src/quadratic_smallest_positive_root.sv */
// Top level: smallest non-negative root of a*x^2+b*x+c, one word per cycle.
//
//   channel  ports                     direction  meaning
//   input    start, busy, in_word      in         coefficients a, b, c (Q16.16)
//   result   out_valid, out_word       out        root (Q16.16) and status
//
// One word is taken every cycle; busy is always low. The pipeline holds
// 2 front stages (products, discriminant), 49 square-root cells, 1 candidate
// stage, 50 divider cells and 1 output stage.
// Synchronous active-low reset clears the valid bits of every cell.
// The receiver cannot stall: each result shows for one cycle with out_valid.
module quadratic_smallest_positive_root import qsr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  qsr_in_t  in_word,
  output logic     out_valid,
  output qsr_out_t out_word
);

  assign busy = 1'b0;

  // ---- stage 1: magnitudes and products
  logic [31:0] ma, mb, mc;
  always_comb begin
    ma = in_word.coef_a[31] ? 32'(-in_word.coef_a) : in_word.coef_a;
    mb = in_word.coef_b[31] ? 32'(-in_word.coef_b) : in_word.coef_b;
    mc = in_word.coef_c[31] ? 32'(-in_word.coef_c) : in_word.coef_c;
  end

  logic              v1_r;
  logic [63:0]       bsq_r, ac_r;
  logic              sgn_diff_r, azero_r, aneg_r;
  logic signed [31:0] b1_r;
  logic [31:0]       ma1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    bsq_r      <= 64'(mb) * 64'(mb);
    ac_r       <= 64'(ma) * 64'(mc);
    sgn_diff_r <= in_word.coef_a[31] != in_word.coef_c[31];
    azero_r    <= in_word.coef_a == '0;
    aneg_r     <= in_word.coef_a[31];
    b1_r       <= in_word.coef_b;
    ma1_r      <= ma;
  end

  // ---- stage 2: discriminant and early status
  logic [65:0] p4, bq, disc;
  logic        cplx;
  always_comb begin
    p4   = {ac_r, 2'b00};
    bq   = {2'b00, bsq_r};
    cplx = !sgn_diff_r && (p4 > bq);
    disc = sgn_diff_r ? (bq + p4) : (bq - p4);
  end

  qsr_side_t       s2_r;
  logic [RadW-1:0] rad2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= v1_r;
    end
    s2_r.done    <= azero_r || cplx;
    s2_r.status  <= azero_r ? ST_AZERO : ST_COMPLEX;
    s2_r.nb_hi   <= -34'(b1_r);
    s2_r.den_neg <= aneg_r;
    s2_r.den_mag <= {ma1_r, 1'b0};
    rad2_r       <= {disc, 32'b0};
  end

  // ---- square-root chain, MSB first
  qsr_side_t        ss [SqrtW+1];
  logic [SqrtW-1:0] sq [SqrtW+1];
  logic [RadW-1:0]  srem [SqrtW+1];

  assign ss[0]   = s2_r;
  assign sq[0]   = '0;
  assign srem[0] = rad2_r;

  for (genvar g = 0; g < SqrtW; g++) begin : g_sqrt
    qsr_sqrt_cell #(.Bit(SqrtW-1-g)) u_cell (
      .clk, .rst_n,
      .side_i(ss[g]), .q_i(sq[g]), .rem_i(srem[g]),
      .side_o(ss[g+1]), .q_o(sq[g+1]), .rem_o(srem[g+1])
    );
  end

  // ---- candidate stage: numerators, signs
  qsr_side_t   sx;
  logic signed [51:0] nb, n0, n1, sroot;
  logic [1:0]  okc;
  logic [NumW-1:0] m0, m1;
  always_comb begin
    sx    = ss[SqrtW];
    nb    = {{2{sx.nb_hi[33]}}, sx.nb_hi, 16'b0};
    sroot = {3'b0, sq[SqrtW]};
    n0    = nb - sroot;
    n1    = nb + sroot;
    okc[0] = (n0 == '0) || ((n0 > 0) == !sx.den_neg);
    okc[1] = (n1 == '0) || ((n1 > 0) == !sx.den_neg);
    m0    = NumW'(n0[51] ? -n0 : n0);
    m1    = NumW'(n1[51] ? -n1 : n1);
  end

  qsr_side_t       c_r;
  logic [1:0]      okc_r;
  logic [NumW-1:0] m0_r, m1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else begin
      c_r.valid <= sx.valid;
    end
    c_r.done    <= sx.done;
    c_r.status  <= sx.status;
    c_r.nb_hi   <= sx.nb_hi;
    c_r.den_neg <= sx.den_neg;
    c_r.den_mag <= sx.den_mag;
    okc_r <= okc;
    m0_r  <= m0;
    m1_r  <= m1;
  end

  // ---- divider chain, MSB first
  qsr_side_t       ds [QW+1];
  logic [1:0]      dok [QW+1];
  logic [NumW-1:0] dr0 [QW+1];
  logic [NumW-1:0] dr1 [QW+1];
  logic [QW-1:0]   dq0 [QW+1];
  logic [QW-1:0]   dq1 [QW+1];

  assign ds[0]  = c_r;
  assign dok[0] = okc_r;
  assign dr0[0] = m0_r;
  assign dr1[0] = m1_r;
  assign dq0[0] = '0;
  assign dq1[0] = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    qsr_div_cell #(.Bit(QW-1-g)) u_cell (
      .clk, .rst_n,
      .side_i(ds[g]), .ok_i(dok[g]), .rem0_i(dr0[g]), .rem1_i(dr1[g]),
      .q0_i(dq0[g]), .q1_i(dq1[g]),
      .side_o(ds[g+1]), .ok_o(dok[g+1]), .rem0_o(dr0[g+1]), .rem1_o(dr1[g+1]),
      .q0_o(dq0[g+1]), .q1_o(dq1[g+1])
    );
  end

  // ---- output stage: pick smaller quotient, saturate
  qsr_side_t  fs;
  logic [1:0] fok;
  logic [QW-1:0] best;
  qsr_out_t   res;
  always_comb begin
    fs   = ds[QW];
    fok  = dok[QW];
    best = (fok[0] && (!fok[1] || dq0[QW] <= dq1[QW])) ? dq0[QW] : dq1[QW];
    res.root   = '1;
    res.status = ST_FOUND;
    if (fs.done) begin
      res.status = fs.status;
    end else if (fok == 2'b00) begin
      res.status = ST_NONEG;
    end else begin
      res.root = (best[QW-1:32] != '0) ? 32'hFFFF_FFFF : best[31:0];
    end
  end

  logic     ov_r;
  qsr_out_t ow_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= fs.valid;
    end
    ow_r <= res;
  end

  assign out_valid = ov_r;
  assign out_word  = ow_r;

endmodule
